// File: src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, register indexes and fixed-point constants of the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;
  localparam logic [CfgIdxW-1:0] CfgDistPerDeg = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvWheelBase = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOdoWeight = 2'd2;

  localparam logic [15:0] DistPerDegRst = 16'd3203;
  localparam logic [15:0] InvWheelBaseRst = 16'd4520;
  localparam logic [16:0] OdoWeightRst = 17'd19661;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries = 24;

  localparam logic signed [19:0] TwoPiQ16 = 20'sd411775;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic [26:0] DegToRadQ32 = 27'd74961353;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = (i < 5'd24) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction
endpackage

// File: src/ddo_if.sv
// ----------------------------------------------------------------------------
// ddo_in_if / ddo_out_if
// Valid/ready channels carrying the tick item and the result item.
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic signed [31:0] gyro_degrees;
  modport source (output valid, left_count, right_count, gyro_degrees, input ready);
  modport sink (input valid, left_count, right_count, gyro_degrees, output ready);
endinterface

interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

// File: src/diff_drive_odometry_gyro_blend_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_gyro_blend_unit
// Differential-drive odometry with gyro heading blend.
// ----------------------------------------------------------------------------
// One item at a time. After acceptance the stored heading is reduced modulo
// 2*pi by a compare-and-subtract loop, folded into [-pi/2, pi/2], then
// CORDIC_STEPS rotations (at most 24) run one per cycle. A shared
// shift-add multiplier then works through seven products (travel, x, y,
// heading delta, gyro and the two blend terms), each over nine 4-bit
// multiplier digits after a load, and a final step commits the state. The
// result waits in an output register; the next item is taken the cycle after
// it has been delivered.
module diff_drive_odometry_gyro_blend_unit
  import ddo_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ddo_in_if.sink in_if,
  ddo_out_if.source out_if
);
  localparam int unsigned Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);
  localparam logic [3:0] LastDigit = 4'd8;
  localparam logic [3:0] Digits = 4'd9;
  localparam logic [3:0] ModTopShift = 4'd12;

  localparam logic [3:0] StIdle = 4'd0, StRed = 4'd1, StCord = 4'd2, StTrav = 4'd3,
    StX = 4'd4, StY = 4'd5, StDth = 4'd6, StGyro = 4'd7, StBlA = 4'd8,
    StBlB = 4'd9, StOut = 4'd10, StMod = 4'd11;

  logic [3:0] st_q, st_d;
  logic [15:0] dpd_q, iwb_q;
  logic [16:0] ow_q;
  logic signed [31:0] px_q, py_q, hd_q, ll_q, lr_q;
  logic signed [31:0] lc_q, rc_q, gd_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic neg_q;
  logic [4:0] it_q;
  // heading magnitude reduction: remainder and current shift of 2*pi
  logic [31:0] rem_q;
  logic [3:0] rk_q;
  // serial multiplier: acc += a * digit, a shifted left 4 each cycle while digits remain
  logic signed [95:0] acc_q, ma_q;
  logic [35:0] mb_q;
  logic [3:0] dg_q;
  logic signed [34:0] trav_q;
  logic signed [31:0] hodo_q, g_q;
  logic signed [31:0] ox_q, oy_q, oh_q;
  logic ovalid_q;

  assign in_if.ready = (st_q == StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.pos_x = ox_q;
  assign out_if.pos_y = oy_q;
  assign out_if.heading = oh_q;

  function automatic logic signed [95:0] rsh(input logic signed [95:0] v, input int n);
    return (v + (96'sd1 <<< (n - 1))) >>> n;
  endfunction
  function automatic logic signed [31:0] sat(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [32:0] dl, dr;
  logic signed [33:0] dsum, ddif;
  logic [31:0] msub;
  logic signed [33:0] xs, ys;
  logic mdone;
  logic signed [4:0] dig;
  logic signed [95:0] prod;
  logic [16:0] wq;
  assign dl = 33'(lc_q) - 33'(ll_q);
  assign dr = 33'(rc_q) - 33'(lr_q);
  assign dsum = 34'(dl) + 34'(dr);
  assign ddif = 34'(dl) - 34'(dr);
  assign msub = 32'(TwoPiQ16) << rk_q;
  assign xs = cx_q >>> it_q;
  assign ys = cy_q >>> it_q;
  assign mdone = (dg_q == Digits);
  // top digit of the multiplier carries the sign
  assign dig = (dg_q == LastDigit) ? $signed({mb_q[3], mb_q[3:0]})
                                   : $signed({1'b0, mb_q[3:0]});
  assign prod = acc_q + ma_q * 96'(dig);
  assign wq = (ow_q > 17'd65536) ? 17'd65536 : ow_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_if.valid && in_if.ready) st_d = StMod;
      StMod: if (rk_q == 4'd0) st_d = StRed;
      StRed: st_d = StCord;
      StCord: if (it_q == LastStep) st_d = StTrav;
      StTrav, StX, StY, StDth, StGyro, StBlA, StBlB:
        if (mdone) st_d = (st_q == StBlB) ? StOut : 4'(st_q + 4'd1);
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // load of the multiplier for a given stage
  task automatic mload(input logic signed [95:0] a, input logic [35:0] b);
    acc_q <= '0; ma_q <= a; mb_q <= b; dg_q <= '0;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ovalid_q <= 1'b0;
      dg_q <= Digits;
      dpd_q <= DistPerDegRst; iwb_q <= InvWheelBaseRst; ow_q <= OdoWeightRst;
      px_q <= '0; py_q <= '0; hd_q <= '0; ll_q <= '0; lr_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDistPerDeg: dpd_q <= cfg_data_i[15:0];
          CfgInvWheelBase: iwb_q <= cfg_data_i[15:0];
          CfgOdoWeight: ow_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      if (!mdone) begin
        acc_q <= prod; ma_q <= ma_q <<< 4; mb_q <= mb_q >> 4; dg_q <= dg_q + 4'd1;
      end
      unique case (st_q)
        StIdle: if (in_if.valid && in_if.ready) begin
          lc_q <= in_if.left_count; rc_q <= in_if.right_count;
          gd_q <= in_if.gyro_degrees;
          rem_q <= hd_q[31] ? unsigned'(-hd_q) : unsigned'(hd_q);
          rk_q <= ModTopShift;
        end
        StMod: begin
          if (rem_q >= msub) rem_q <= rem_q - msub;
          rk_q <= rk_q - 4'd1;
        end
        StRed: begin
          logic signed [20:0] r;
          // remainder of a negative heading takes the sign, then moves to [0, 2*pi)
          r = 21'(rem_q[18:0]);
          if (hd_q[31] && (r != 21'sd0)) r = 21'(TwoPiQ16) - r;
          if (r > 21'(PiQ16)) r = r - 21'(TwoPiQ16);
          neg_q <= 1'b0;
          if (r > 21'(HalfPiQ16)) begin r = r - 21'(PiQ16); neg_q <= 1'b1; end
          else if (r < -21'(HalfPiQ16)) begin r = r + 21'(PiQ16); neg_q <= 1'b1; end
          cz_q <= 34'(r) <<< 14;
          cx_q <= CordicGainQ30; cy_q <= '0; it_q <= '0;
        end
        StCord: begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atan_q30(it_q);
          end else begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atan_q30(it_q);
          end
          it_q <= it_q + 5'd1;
          if (it_q == LastStep) mload(96'(dsum), 36'(dpd_q));
        end
        StTrav: if (mdone) begin
          logic signed [95:0] t;
          t = rsh(acc_q, 9);
          if (t > (96'sd1 <<< 32)) t = 96'sd1 <<< 32;
          if (t < -(96'sd1 <<< 32)) t = -(96'sd1 <<< 32);
          trav_q <= 35'(t);
          if (neg_q) begin cx_q <= -cx_q; cy_q <= -cy_q; end
          mload(96'(t), neg_q ? 36'(-cx_q) : 36'(cx_q));
        end
        StX: if (mdone) begin
          ox_q <= sat(96'(px_q) + rsh(acc_q, 30));
          mload(96'(trav_q), 36'(cy_q));
        end
        StY: if (mdone) begin
          oy_q <= sat(96'(py_q) + rsh(acc_q, 30));
          mload(96'(ddif) * 96'(dpd_q), 36'(iwb_q));
        end
        StDth: if (mdone) begin
          hodo_q <= sat(96'(hd_q) + rsh(acc_q, 16));
          mload(96'(gd_q), 36'(DegToRadQ32));
        end
        StGyro: if (mdone) begin
          g_q <= sat(-rsh(acc_q, 16));
          mload(96'(hodo_q), 36'(wq));
        end
        StBlA: if (mdone) begin
          ma_q <= 96'(g_q); mb_q <= 36'(17'd65536 - wq); dg_q <= '0;
        end
        StBlB: if (mdone) begin
          oh_q <= sat(rsh(acc_q, 16));
        end
        StOut: begin
          px_q <= ox_q; py_q <= oy_q; hd_q <= oh_q; ll_q <= lc_q; lr_q <= rc_q;
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: src/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry block.
// ----------------------------------------------------------------------------
module ddo_port_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic signed [31:0] pos_x_i
);
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("second item taken");
  a_no_out_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i) else $error("result too early");
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("taken with result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(pos_x_i))
    else $error("result lost");
endmodule

bind diff_drive_odometry_gyro_blend_unit ddo_port_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .pos_x_i(out_if.pos_x)
);

// File: tb/ddo_tb_if.sv
// ----------------------------------------------------------------------------
// ddo_tb_if
// Channel timing of the testbench: driven at the falling edge, sampled at the
// rising edge. The channels are the ddo_in_if / ddo_out_if interfaces in src.
// ----------------------------------------------------------------------------

// File: tb/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Watches config writes and both channels, predicts each pose update and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module ddo_checker
  import ddo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ddo_in_if in_if,
  ddo_out_if out_if,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned poses_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hd;
  } pose_t;

  pose_t pose_q[$];
  logic signed [31:0] px, py, hdg, last_l, last_r;
  logic [15:0] dpd, iwb;
  logic [16:0] wgt;

  function automatic longint shr_round(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    return longint'(1) <<< (30 - i);
  endfunction

  task automatic heading_sincos(input longint h, output longint c, output longint s);
    longint r, x, y, z, xs, ys;
    bit flip;
    r = h % 411775;
    flip = 0;
    x = 652032874;
    y = 0;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    if (r > 102944) begin
      r -= 205887; flip = 1;
    end else if (r < -102944) begin
      r += 205887; flip = 1;
    end
    z = r * 16384;
    for (int i = 0; i < CordicStepsDef && i < AtanEntries; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input logic signed [31:0] l, r, g);
    longint dl, dr, c, s, trav, nx, ny, t, hi, lo, dth, hodo, gr, hb, w, tc, ts;
    pose_t p;
    dl = longint'(l) - longint'(last_l);
    dr = longint'(r) - longint'(last_r);
    w = (wgt > 17'd65536) ? 65536 : longint'(wgt);
    heading_sincos(longint'(hdg), c, s);
    trav = shr_round((dl + dr) * longint'(dpd), 9);
    if (trav > (longint'(1) <<< 32)) trav = longint'(1) <<< 32;
    if (trav < -(longint'(1) <<< 32)) trav = -(longint'(1) <<< 32);
    // |trav|<=2^32, |c|<=2^30: product fits in 64 bits
    tc = trav * c;
    ts = trav * s;
    nx = sat_s32(longint'(px) + shr_round(tc, 30));
    ny = sat_s32(longint'(py) + shr_round(ts, 30));
    t = (dl - dr) * longint'(dpd);
    hi = t >>> 16;
    lo = t - hi * 65536;
    dth = hi * longint'(iwb) + ((lo * longint'(iwb) + 32768) >>> 16);
    hodo = sat_s32(longint'(hdg) + dth);
    gr = sat_s32(-shr_round(longint'(g) * 74961353, 16));
    hb = sat_s32(shr_round(w * hodo + (65536 - w) * gr, 16));
    px = 32'(nx); py = 32'(ny); hdg = 32'(hb); last_l = l; last_r = r;
    p.x = 32'(nx); p.y = 32'(ny); p.hd = 32'(hb);
    pose_q.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      px = '0; py = '0; hdg = '0; last_l = '0; last_r = '0;
      dpd = DistPerDegRst; iwb = InvWheelBaseRst; wgt = OdoWeightRst;
      errors_o <= 0; poses_o <= 0;
      pose_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDistPerDeg:   dpd = cfg_data_i[15:0];
          CfgInvWheelBase: iwb = cfg_data_i[15:0];
          CfgOdoWeight:    wgt = cfg_data_i;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        predict_pose(in_if.left_count, in_if.right_count, in_if.gyro_degrees);
      if (out_if.valid && out_if.ready) begin
        poses_o <= poses_o + 1;
        if (pose_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected pose item x=%0d y=%0d h=%0d",
                                      out_if.pos_x, out_if.pos_y, out_if.heading);
          errors_o <= errors_o + 1;
        end else begin
          e = pose_q.pop_front();
          if (e.x !== out_if.pos_x || e.y !== out_if.pos_y || e.hd !== out_if.heading) begin
            if (errors_o < 10)
              $display("pose mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
                       e.x, e.y, e.hd, out_if.pos_x, out_if.pos_y, out_if.heading);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = pose_q.size();
endmodule

// File: tb/tb_diff_drive_odometry_gyro_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_gyro_blend_unit
// Drives encoder/gyro ticks and register writes into the odometry block with
// random gaps and output stalls; the checker predicts and compares every pose.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_gyro_blend_unit;
  import ddo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgDistPerDeg;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned errors, pending, poses, ticks;
  bit hold_off = 0;
  logic signed [31:0] enc_l = 0, enc_r = 0;

  ddo_in_if in_if ();
  ddo_out_if out_if ();

  always #1 clk_i = ~clk_i;

  diff_drive_odometry_gyro_blend_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  ddo_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if), .out_if(out_if),
    .errors_o(errors), .pending_o(pending), .poses_o(poses)
  );

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall per item, long hold-off on request
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        gap = 400;
        hold_off = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  task automatic send_tick(input logic signed [31:0] l, r, g, input int gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.left_count <= l;
    in_if.right_count <= r;
    in_if.gyro_degrees <= g;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    ticks++;
    enc_l = l;
    enc_r = r;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_ticks(input int n);
    logic signed [31:0] l, r, g;
    int gap;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin l = $urandom; r = $urandom; g = $urandom; end
        1: begin
          l = enc_l + $signed($urandom_range(0, 2000000)) - 1000000;
          r = enc_r + $signed($urandom_range(0, 2000000)) - 1000000;
          g = $signed($urandom_range(0, 4000000)) - 2000000;
        end
        default: begin
          l = enc_l + $signed($urandom_range(0, 800)) - 400;
          r = enc_r + $signed($urandom_range(0, 800)) - 400;
          g = $signed($urandom_range(0, 7200)) - 3600;
        end
      endcase
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      send_tick(l, r, g, gap);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.left_count = '0;
    in_if.right_count = '0;
    in_if.gyro_degrees = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, straight runs, spins, gyro extremes
    send_tick(0, 0, 0, 0);
    send_tick(360, 360, 0, 0);
    send_tick(720, 0, 90, 1);
    send_tick(720, 720, -90, 0);
    send_tick(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 2);
    send_tick(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_tick(32'sh7fffffff, 32'sh80000000, 0, 0);
    send_tick(32'sh80000000, 32'sh7fffffff, -1, 3);
    send_tick(-1, -1, 180, 0);
    send_tick(1000, -1000, -180, 0);
    send_tick(-5000, 5000, 270, 0);
    send_tick(0, 0, 32'hffffffff, 0);
    drain();

    // weight above one, extremes of the other registers
    write_reg(CfgDistPerDeg, 17'hffff);
    write_reg(CfgInvWheelBase, 17'hffff);
    write_reg(CfgOdoWeight, 17'h1ffff);
    send_tick(100000, -100000, 45, 0);
    send_tick(32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send_tick(32'sh80000000, 32'sh80000000, 0, 0);
    drain();
    write_reg(CfgOdoWeight, 17'd0);
    write_reg(CfgDistPerDeg, 17'd0);
    write_reg(CfgInvWheelBase, 17'd0);
    send_tick(500, 100, 30, 0);
    send_tick(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0);
    drain();
    write_reg(CfgOdoWeight, 17'd65536);
    write_reg(CfgDistPerDeg, 17'd3203);
    write_reg(CfgInvWheelBase, 17'd4520);
    random_ticks(400);

    // stall the output long enough that the input backs up
    hold_off = 1;
    random_ticks(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgDistPerDeg, 17'($urandom_range(0, 65535)));
      write_reg(CfgInvWheelBase, 17'($urandom_range(0, 65535)));
      write_reg(CfgOdoWeight, 17'($urandom_range(0, 70000)));
      random_ticks(380);
      drain();
    end

    $display("Sent %0d ticks over several register settings, checked %0d poses.",
             ticks, poses);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
